// ===== rtl/trpp_pkg.sv =====
// ----------------------------------------------------------------------------
// trpp_pkg
// Shared types and constants of the touch-report packet parser.
// ----------------------------------------------------------------------------
package trpp_pkg;

  // Packet limits.
  localparam int POINT_LIMIT      = 10;
  localparam int MAX_PACKET_BYTES = 64;

  // Derived counter widths.
  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int PC_W  = $clog2(POINT_LIMIT + 1);

  // Packet layout.
  localparam logic [7:0] ID_POINT_MAX  = 8'h0A;
  localparam logic [7:0] ID_GESTURE    = 8'hF6;
  localparam logic [7:0] ID_RESET      = 8'hFF;
  localparam logic [7:0] GESTURE_MASK  = 8'h07;
  localparam logic [7:0] X_HIGH_MASK   = 8'hF0;
  localparam logic [7:0] Y_HIGH_MASK   = 8'h0F;
  localparam int         ID_BYTE       = 4;
  localparam int         GESTURE_BYTE  = 6;
  localparam int         RECORD_LEN    = 6;
  localparam int         POS_WEIGHT    = 4;
  localparam int         POS_LAST      = RECORD_LEN - 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_X        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd4;
  localparam logic [12:0] SCREEN_RESET = 13'd412;

  // Result kinds.
  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result queue depth.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  point_id;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [7:0]  weight;
    logic        pressed;
    logic [2:0]  gesture;
    logic [3:0]  count;
    logic        final_res;
  } out_item_t;

  // Up to two results produced by one byte, first one in res0.
  typedef struct packed {
    logic      valid0;
    logic      valid1;
    out_item_t res0;
    out_item_t res1;
  } push_t;

endpackage

// ===== rtl/trpp_parse.sv =====
// ----------------------------------------------------------------------------
// trpp_parse
// Byte parser: tracks the packet position, unpacks records and builds the
// point and summary results for each accepted byte.
// ----------------------------------------------------------------------------
module trpp_parse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  trpp_pkg::in_item_t            item,
  input  logic                          cfg_write,
  input  logic [trpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trpp_pkg::CFG_DATA_W-1:0] cfg_data,
  output trpp_pkg::push_t               push
);
  import trpp_pkg::*;

  // Configuration registers.
  logic        swap_xy, flip_x, flip_y;
  logic [12:0] screen_width, screen_height;

  // Packet state.
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [7:0]       id_check, id_check_next;
  logic [2:0]       rec_pos, rec_pos_next;
  logic [7:0]       rec_bytes [4];
  logic [7:0]       rec_weight;
  logic [PC_W-1:0]  point_count, point_count_next;
  logic [11:0]      first_x, first_x_next, first_y, first_y_next;
  logic [7:0]       first_w, first_w_next;
  logic [2:0]       gesture_code, gesture_code_next;
  logic [11:0]      held_x, held_y;

  // Per-byte decode.
  logic        in_range, rec_active, point_emit, rec_store, weight_store;
  logic [11:0] pt_x, pt_y;

  // Summary.
  logic [PC_W-1:0] sum_cnt;
  logic [2:0]      sum_ges;
  logic            sum_pressed;
  logic [7:0]      sum_w;
  logic [11:0]     sx, sy, ox, oy;
  logic [11:0]     out_x, out_y;
  out_item_t       point_res, summary_res;

  // Mirror about size-1, clamped to the 12-bit coordinate range.
  function automatic logic [11:0] mirror(input logic [12:0] size, input logic [11:0] v);
    logic [13:0] diff;
    diff = {1'b0, size} - {2'b00, v} - 14'd1;
    if (diff[13]) begin
      mirror = 12'd0;
    end else if (diff[12]) begin
      mirror = 12'hFFF;
    end else begin
      mirror = diff[11:0];
    end
  endfunction

  // Decode the current byte against the packet position.
  always_comb begin
    in_range          = byte_index < IDX_W'(MAX_PACKET_BYTES);
    id_check_next     = id_check;
    byte_index_next   = byte_index;
    rec_pos_next      = rec_pos;
    point_count_next  = point_count;
    first_x_next      = first_x;
    first_y_next      = first_y;
    first_w_next      = first_w;
    gesture_code_next = gesture_code;
    rec_active        = 1'b0;
    point_emit        = 1'b0;
    rec_store         = 1'b0;
    weight_store      = 1'b0;
    pt_x = {rec_bytes[3][7:4] & X_HIGH_MASK[7:4], rec_bytes[1]};
    pt_y = {rec_bytes[3][3:0] & Y_HIGH_MASK[3:0], rec_bytes[2]};
    if (in_range) begin
      if (byte_index == IDX_W'(ID_BYTE)) begin
        id_check_next = item.data_byte;
      end
      rec_active = (byte_index >= IDX_W'(ID_BYTE)) && (id_check_next <= ID_POINT_MAX);
      if (rec_active) begin
        rec_pos_next = (rec_pos == 3'(POS_LAST)) ? 3'd0 : rec_pos + 3'd1;
        if (rec_pos < 3'(POS_WEIGHT)) begin
          rec_store = 1'b1;
        end else if (rec_pos == 3'(POS_WEIGHT)) begin
          weight_store = 1'b1;
        end else if (point_count < PC_W'(POINT_LIMIT)) begin
          point_emit       = 1'b1;
          point_count_next = point_count + PC_W'(1);
          if (point_count == '0) begin
            first_x_next = pt_x;
            first_y_next = pt_y;
            first_w_next = rec_weight;
          end
        end
      end else if ((byte_index == IDX_W'(GESTURE_BYTE)) && (id_check_next == ID_GESTURE)) begin
        gesture_code_next = 3'(item.data_byte & GESTURE_MASK);
      end
      byte_index_next = byte_index + IDX_W'(1);
    end
  end

  // Summary over the state as it stands after this byte.
  always_comb begin
    sum_cnt = (id_check_next <= ID_POINT_MAX) ? point_count_next : '0;
    sum_ges = (id_check_next == ID_GESTURE) ? gesture_code_next : 3'd0;
    sum_w   = (sum_cnt != '0) ? first_w_next : 8'd0;
    sum_pressed = (sum_cnt != '0) && (first_w_next != 8'd0);
    sx = swap_xy ? first_y_next : first_x_next;
    sy = swap_xy ? first_x_next : first_y_next;
    ox = flip_x ? mirror(screen_width, sx) : sx;
    oy = flip_y ? mirror(screen_height, sy) : sy;
    out_x = sum_pressed ? ox : held_x;
    out_y = sum_pressed ? oy : held_y;
  end

  // Result items.
  always_comb begin
    point_res           = '0;
    point_res.kind      = KIND_POINT;
    point_res.point_id  = rec_bytes[0];
    point_res.coord_x   = pt_x;
    point_res.coord_y   = pt_y;
    point_res.weight    = rec_weight;
    point_res.final_res = !item.end_of_packet;

    summary_res           = '0;
    summary_res.kind      = KIND_SUMMARY;
    summary_res.coord_x   = out_x;
    summary_res.coord_y   = out_y;
    summary_res.weight    = sum_w;
    summary_res.pressed   = sum_pressed;
    summary_res.gesture   = sum_ges;
    summary_res.count     = (sum_cnt > PC_W'(15)) ? 4'd15 : 4'(sum_cnt);
    summary_res.final_res = 1'b1;

    push.valid0 = accept && (point_emit || item.end_of_packet);
    push.valid1 = accept && point_emit && item.end_of_packet;
    push.res0   = point_emit ? point_res : summary_res;
    push.res1   = summary_res;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      swap_xy       <= 1'b0;
      flip_x        <= 1'b0;
      flip_y        <= 1'b0;
      screen_width  <= SCREEN_RESET;
      screen_height <= SCREEN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SWAP_XY:       swap_xy       <= cfg_data[0];
        REG_FLIP_X:        flip_x        <= cfg_data[0];
        REG_FLIP_Y:        flip_y        <= cfg_data[0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Packet state: advances on each transfer, clears after a summary.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      id_check     <= ID_RESET;
      rec_pos      <= '0;
      point_count  <= '0;
      first_x      <= '0;
      first_y      <= '0;
      first_w      <= '0;
      gesture_code <= '0;
      held_x       <= '0;
      held_y       <= '0;
      rec_weight   <= '0;
      for (int i = 0; i < 4; i++) begin
        rec_bytes[i] <= '0;
      end
    end else if (accept) begin
      if (item.end_of_packet) begin
        byte_index   <= '0;
        id_check     <= ID_RESET;
        rec_pos      <= '0;
        point_count  <= '0;
        first_x      <= '0;
        first_y      <= '0;
        first_w      <= '0;
        gesture_code <= '0;
        held_x       <= out_x;
        held_y       <= out_y;
        rec_weight   <= '0;
        for (int i = 0; i < 4; i++) begin
          rec_bytes[i] <= '0;
        end
      end else begin
        byte_index   <= byte_index_next;
        id_check     <= id_check_next;
        rec_pos      <= rec_pos_next;
        point_count  <= point_count_next;
        first_x      <= first_x_next;
        first_y      <= first_y_next;
        first_w      <= first_w_next;
        gesture_code <= gesture_code_next;
        if (rec_store) begin
          rec_bytes[rec_pos[1:0]] <= item.data_byte;
        end
        if (weight_store) begin
          rec_weight <= item.data_byte;
        end
      end
    end
  end

endmodule

// ===== rtl/trpp_outq.sv =====
// ----------------------------------------------------------------------------
// trpp_outq
// Small result queue: takes up to two results per cycle and hands out one
// per transfer. Holds off input while fewer than two slots are free.
// ----------------------------------------------------------------------------
module trpp_outq (
  input  logic                clk,
  input  logic                rst,
  input  trpp_pkg::push_t     push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output trpp_pkg::out_item_t out_data
);
  import trpp_pkg::*;

  out_item_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   fill, fill_next;
  logic                pop;
  logic [QPTR_W-1:0]   wr_ptr_1;

  assign out_valid = fill != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;
  assign full      = fill > QCNT_W'(QUEUE_DEPTH - 2);
  assign wr_ptr_1  = wr_ptr + QPTR_W'(1);

  // Fill level after this cycle's pushes and pop.
  always_comb begin
    fill_next = fill + QCNT_W'(push.valid0) + QCNT_W'(push.valid1) - QCNT_W'(pop);
  end

  // Pointers and level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push.valid1) begin
        wr_ptr <= wr_ptr + QPTR_W'(2);
      end else if (push.valid0) begin
        wr_ptr <= wr_ptr_1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.valid0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.valid1) begin
      entries[wr_ptr_1] <= push.res1;
    end
  end

endmodule

// ===== rtl/touch_report_packet_parser_top.sv =====
// ----------------------------------------------------------------------------
// touch_report_packet_parser_top
// Parses touch-report packets byte by byte into point and summary results.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall   in_item_t (data_byte, end_of_packet)
//   out      output     out_valid / out_stall out_item_t (kind ... final_res)
//   cfg      input      cfg_write            cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; its results enter a
// four-entry queue in the same cycle and leave it one per transfer.
// in_stall rises while fewer than two queue slots are free, so a byte that
// closes a record and the packet together always fits.
// Reset is synchronous and returns the configuration to its defaults.
// ----------------------------------------------------------------------------
module touch_report_packet_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  trpp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output trpp_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [trpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trpp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import trpp_pkg::*;

  push_t push;
  logic  accept;
  logic  full;

  // A byte transfers when the queue has room for two results.
  assign in_stall = full;
  assign accept   = in_valid && !full;

  trpp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push)
  );

  trpp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the touch-report packet parser. A driver feeds
// packet bytes from a queue, a monitor predicts the point and summary
// results of every accepted byte and compares each output transfer field by
// field. The run goes through several orientation and screen-size settings
// under varied sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trpp_pkg::*;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Bytes waiting for the driver and results waiting for the output.
  in_item_t  byte_q[$];
  out_item_t pending_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int          err_cnt        = 0;
  int          bytes_taken    = 0;
  int          points_seen    = 0;
  int          summaries_seen = 0;

  // Orientation settings as the parser holds them.
  logic        orient_swap = 1'b0;
  logic        orient_mx   = 1'b0;
  logic        orient_my   = 1'b0;
  logic [12:0] scr_width   = SCREEN_RESET;
  logic [12:0] scr_height  = SCREEN_RESET;

  // Packet state of the parser.
  int unsigned pk_index = 0;
  logic [7:0]  pk_id    = ID_RESET;
  logic [7:0]  rec [4]  = '{default: 8'h00};
  logic [7:0]  rec_w    = 8'h00;
  int unsigned pt_cnt   = 0;
  logic [11:0] first_x  = '0;
  logic [11:0] first_y  = '0;
  logic [7:0]  first_w  = 8'h00;
  logic [2:0]  ges      = '0;
  logic [11:0] held_x   = '0;
  logic [11:0] held_y   = '0;

  touch_report_packet_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflect a coordinate against a screen size, clamped to the 12-bit range.
  function automatic logic [11:0] mirror_coord(input logic [12:0] size,
                                               input logic [11:0] v);
    int r;
    r = int'(size) - 1 - int'(v);
    if (r < 0) return 12'h000;
    if (r > 4095) return 12'hFFF;
    return 12'(r);
  endfunction

  // Work out the results of one accepted byte and queue them in order.
  task automatic predict_byte(input in_item_t it);
    out_item_t   step_res[$];
    out_item_t   r;
    int unsigned pos;
    logic [11:0] px, py;
    logic [3:0]  cnt;
    logic [2:0]  g;
    logic [7:0]  w;
    logic        pr;
    if (pk_index < MAX_PACKET_BYTES) begin
      if (pk_index == ID_BYTE) pk_id = it.data_byte;
      if (pk_index >= ID_BYTE && pk_id <= ID_POINT_MAX) begin
        pos = (pk_index - ID_BYTE) % RECORD_LEN;
        if (pos < POS_WEIGHT) begin
          rec[pos] = it.data_byte;
        end else if (pos == POS_WEIGHT) begin
          rec_w = it.data_byte;
        end else if (pt_cnt < POINT_LIMIT) begin
          // A complete record: x takes the high nibble, y the low one.
          px = {rec[3][7:4], rec[1]};
          py = {rec[3][3:0], rec[2]};
          if (pt_cnt == 0) begin
            first_x = px;
            first_y = py;
            first_w = rec_w;
          end
          pt_cnt++;
          r          = '0;
          r.kind     = KIND_POINT;
          r.point_id = rec[0];
          r.coord_x  = px;
          r.coord_y  = py;
          r.weight   = rec_w;
          step_res.push_back(r);
        end
      end else if (pk_index == GESTURE_BYTE && pk_id == ID_GESTURE) begin
        ges = 3'(it.data_byte & GESTURE_MASK);
      end
      pk_index++;
    end

    // The packet end closes with a summary and clears all but the held point.
    if (it.end_of_packet) begin
      cnt = '0;
      g   = '0;
      w   = 8'h00;
      pr  = 1'b0;
      if (pk_id <= ID_POINT_MAX) begin
        cnt = (pt_cnt > 15) ? 4'd15 : 4'(pt_cnt);
      end else if (pk_id == ID_GESTURE) begin
        g = ges;
      end
      if (cnt != 0) begin
        w = first_w;
        if (w != 0) begin
          pr = 1'b1;
          px = orient_swap ? first_y : first_x;
          py = orient_swap ? first_x : first_y;
          if (orient_mx) px = mirror_coord(scr_width, px);
          if (orient_my) py = mirror_coord(scr_height, py);
          held_x = px;
          held_y = py;
        end
      end
      r         = '0;
      r.kind    = KIND_SUMMARY;
      r.coord_x = held_x;
      r.coord_y = held_y;
      r.weight  = w;
      r.pressed = pr;
      r.gesture = g;
      r.count   = cnt;
      step_res.push_back(r);
      pk_index = 0;
      pk_id    = ID_RESET;
      rec      = '{default: 8'h00};
      rec_w    = 8'h00;
      pt_cnt   = 0;
      first_x  = '0;
      first_y  = '0;
      first_w  = 8'h00;
      ges      = '0;
    end

    if (step_res.size() > 0) step_res[step_res.size() - 1].final_res = 1'b1;
    foreach (step_res[i]) pending_results.push_back(step_res[i]);
  endtask

  task automatic check_field(input string fname, input int unsigned e,
                             input int unsigned a);
    if (e != a) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, e, a);
    end
  endtask

  // Driver: present the next queued byte once the current one is taken.
  always @(posedge clk) begin
    if (!rst && (!in_valid || !in_stall)) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on every input transfer, check every output transfer.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_byte(in_data);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, got %h", $time, out_data);
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, out_data.kind);
          check_field("point_id", want.point_id, out_data.point_id);
          check_field("coord_x", want.coord_x, out_data.coord_x);
          check_field("coord_y", want.coord_y, out_data.coord_y);
          check_field("weight", want.weight, out_data.weight);
          check_field("pressed", want.pressed, out_data.pressed);
          check_field("gesture", want.gesture, out_data.gesture);
          check_field("count", want.count, out_data.count);
          check_field("final_res", want.final_res, out_data.final_res);
          if (want.kind == KIND_SUMMARY) summaries_seen++;
          else points_seen++;
        end
      end
    end
  end

  // Register write; the local copy follows it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SWAP_XY:       orient_swap = val[0];
      REG_FLIP_X:        orient_mx   = val[0];
      REG_FLIP_Y:        orient_my   = val[0];
      REG_SCREEN_WIDTH:  scr_width   = val;
      REG_SCREEN_HEIGHT: scr_height  = val;
      default: ;
    endcase
  endtask

  // Queue one packet; the last byte carries the end marker.
  task automatic queue_packet(input logic [7:0] pkt[$]);
    in_item_t it;
    foreach (pkt[i]) begin
      it.data_byte     = pkt[i];
      it.end_of_packet = (i == pkt.size() - 1);
      byte_q.push_back(it);
    end
  endtask

  // Build one packet of the kind that sel picks.
  task automatic queue_random_packet(input int sel);
    logic [7:0]  pkt[$];
    logic [7:0]  r6 [6];
    logic [7:0]  id;
    logic [11:0] x, y;
    int          nrec, tail, len;
    repeat (4) pkt.push_back(8'($urandom));
    if (sel < 70) begin
      // Touch report: mostly a few records, sometimes a cut-off last one.
      nrec = ($urandom_range(3) == 0) ? $urandom_range(POINT_LIMIT) : $urandom_range(3);
      tail = ($urandom_range(3) == 0) ? $urandom_range(1, POS_LAST) : 0;
      if (nrec == 0 && tail == 0) tail = 1;
      for (int k = 0; k < nrec + ((tail != 0) ? 1 : 0); k++) begin
        x = 12'($urandom);
        y = 12'($urandom);
        if ($urandom_range(7) == 0) x = $urandom_range(1) ? 12'hFFF : 12'h000;
        if ($urandom_range(7) == 0) y = $urandom_range(1) ? 12'hFFF : 12'h000;
        r6[0] = (k == 0) ? 8'($urandom_range(ID_POINT_MAX)) : 8'($urandom);
        r6[1] = x[7:0];
        r6[2] = y[7:0];
        r6[3] = {x[11:8], y[11:8]};
        r6[4] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
        r6[5] = 8'($urandom);
        for (int j = 0; j < ((k < nrec) ? RECORD_LEN : tail); j++) pkt.push_back(r6[j]);
      end
    end else if (sel < 80) begin
      // Gesture report, sometimes ending before the gesture byte.
      pkt.push_back(ID_GESTURE);
      repeat ($urandom_range(4)) pkt.push_back(8'($urandom));
    end else if (sel < 88) begin
      // Unknown id check.
      do id = 8'($urandom_range(8'hFF, 8'h0B)); while (id == ID_GESTURE);
      pkt.push_back(id);
      repeat ($urandom_range(8)) pkt.push_back(8'($urandom));
    end else if (sel < 93) begin
      // Packet that ends inside the header.
      pkt.delete();
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
    end else if (sel < 96) begin
      // Packet running past the byte limit.
      pkt.push_back(8'($urandom_range(ID_POINT_MAX)));
      len = MAX_PACKET_BYTES + $urandom_range(1, 8);
      while (pkt.size() < len) pkt.push_back(8'($urandom));
    end else begin
      // Noise of random length.
      pkt.delete();
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
    end
    queue_packet(pkt);
  endtask

  // Wait until every byte is taken and every result has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (byte_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Stimulus and end of run.
  initial begin
    logic [2:0]  orient_set [6];
    logic [12:0] width_set  [6];
    logic [12:0] height_set [6];
    orient_set = '{3'b000, 3'b111, 3'b011, 3'b110, 3'b000, 3'b101};
    width_set  = '{13'd412, 13'd1, 13'd4096, 13'd8191, 13'd412, 13'd100};
    height_set = '{13'd412, 13'd1, 13'd4096, 13'd4100, 13'd412, 13'd3000};
    orient_set[4] = 3'($urandom);
    width_set[4]  = 13'($urandom_range(1, 4096));
    height_set[4] = 13'($urandom_range(1, 4096));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed packets at the reset settings: end on the first byte, a full
    // record at the largest coordinates, the largest gesture, a short header.
    queue_packet('{8'h00});
    queue_packet('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    queue_packet('{8'h00, 8'hFF, 8'h00, 8'hFF, ID_GESTURE, 8'h00, 8'hFF});
    queue_packet('{8'h01, 8'h02, 8'h03});
    wait_idle();

    // Random phases, each with its own settings and one of four flow-control patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SWAP_XY, CFG_DATA_W'(orient_set[ph][2]));
      write_reg(REG_FLIP_X, CFG_DATA_W'(orient_set[ph][1]));
      write_reg(REG_FLIP_Y, CFG_DATA_W'(orient_set[ph][0]));
      write_reg(REG_SCREEN_WIDTH, width_set[ph]);
      write_reg(REG_SCREEN_HEIGHT, height_set[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 1) queue_random_packet(94);
      while (byte_q.size() < 60) queue_random_packet($urandom_range(99));
      wait_idle();
    end

    $display("Checked %0d point and %0d summary results from %0d input bytes,",
             points_seen, summaries_seen, bytes_taken);
    $display("over six orientation and screen settings and four flow-control patterns.");
    if (err_cnt == 0) begin
      $display("** touch_report_packet_parser_top: PASSED **");
    end else begin
      $display("** touch_report_packet_parser_top: FAILED **");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results still expected.", pending_results.size());
    $display("** touch_report_packet_parser_top: FAILED **");
    $finish;
  end

endmodule
